// File: hw/rtl/ihpc_pkg.sv
// types and constants shared by the ipv4 header parse and check block
package ihpc_pkg;

    localparam int unsigned CNT_W         = 6;
    localparam int unsigned MIN_HDR_WORDS = 5;

    // byte positions within the header
    localparam logic [CNT_W-1:0] IDX_TTL      = 6'd8;
    localparam logic [CNT_W-1:0] IDX_CSUM     = 6'd10;
    localparam logic [CNT_W-1:0] IDX_CSUM_LO  = 6'd11;
    localparam logic [CNT_W-1:0] IDX_ADDR     = 6'd12;
    localparam logic [CNT_W-1:0] IDX_ADDR_END = 6'd20;
    localparam logic [CNT_W-1:0] IDX_MAX      = 6'd60;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       start_of_header;
    } ihpc_in_t;

    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [5:0]  dscp;
        logic [1:0]  ecn;
        logic [15:0] tot_len;
        logic [15:0] identification;
        logic [2:0]  flag_bits;
        logic [12:0] frag_off;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [63:0] address_pair;
        logic        checksum_ok;
    } ihpc_out_t;

    // 16-bit ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: hw/rtl/ipv4_header_parse_check.sv
// IPv4 header parser with header checksum check, one byte per cycle while no finished result waits on a low m_ready
//
// Takes an IPv4 header one byte a cycle in network order; start_of_header marks
// byte 0 and restarts any header in progress. Bytes without a start marker while
// idle are taken and dropped. After max(header_words,5)*4 bytes one result comes
// out holding the header fields and whether the ones' complement sum (checksum
// bytes counted as zero), complemented, equals the received checksum. The field
// capture, the running checksum add and the span compare sit between the byte
// handshake and the result register, so s_ready stays high in every cycle except
// when a finished result waits and m_ready is low. The result is visible on
// m_ports the cycle after the last header byte is accepted.
module ipv4_header_parse_check
    import ihpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ihpc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ihpc_out_t m_data
);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;
    logic [15:0]      csum_reg, csum_next;
    logic [63:0]      fields_reg, fields_next;
    logic [63:0]      addr_reg, addr_next;
    logic [15:0]      tp_reg, tp_next;
    logic             m_valid_reg, m_valid_next;
    ihpc_out_t        out_reg, out_next;

    logic             accept;
    logic             work;
    logic [CNT_W-1:0] idx;
    logic [15:0]      sum_base;
    logic [3:0]       hw_eff;
    logic [CNT_W:0]   span;
    logic             last;
    logic [7:0]       b;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.header_byte;
    assign work    = accept && (s_data.start_of_header || active_reg);
    assign idx     = s_data.start_of_header ? '0 : cnt_reg;
    assign sum_base = s_data.start_of_header ? 16'd0 : sum_reg;

    // fields_reg holds byte 0 at the top once eight bytes are in; before that the
    // span is at least 20 so the compare below cannot fire on a stale nibble
    assign hw_eff = (fields_reg[59:56] < 4'(MIN_HDR_WORDS)) ? 4'(MIN_HDR_WORDS)
                                                             : fields_reg[59:56];
    assign span   = {1'b0, hw_eff, 2'b00};
    assign last   = ({1'b0, idx} + 7'd1) >= span;

    always_comb begin
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        pend_next    = pend_reg;
        csum_next    = csum_reg;
        fields_next  = fields_reg;
        addr_next    = addr_reg;
        tp_next      = tp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;

        if (work) begin
            sum_next = sum_base;
            if (idx < IDX_TTL) begin
                fields_next = {fields_reg[55:0], b};
            end else if (idx < IDX_CSUM) begin
                tp_next = {tp_reg[7:0], b};
            end else if (idx < IDX_ADDR) begin
                csum_next = {csum_reg[7:0], b};
            end else if (idx < IDX_ADDR_END) begin
                addr_next = {addr_reg[55:0], b};
            end

            if (!idx[0]) begin
                pend_next = b;
            end else if (idx != IDX_CSUM_LO) begin
                sum_next = ones_add(sum_base, {pend_reg, b});
            end

            if (last) begin
                active_next  = 1'b0;
                cnt_next     = '0;
                m_valid_next = 1'b1;
                out_next.version        = fields_next[63:60];
                out_next.header_words   = fields_next[59:56];
                out_next.dscp           = fields_next[55:50];
                out_next.ecn            = fields_next[49:48];
                out_next.tot_len        = fields_next[47:32];
                out_next.identification = fields_next[31:16];
                out_next.flag_bits      = fields_next[15:13];
                out_next.frag_off       = fields_next[12:0];
                out_next.ttl            = tp_next[15:8];
                out_next.protocol       = tp_next[7:0];
                out_next.address_pair   = addr_next;
                out_next.checksum_ok    = (~sum_next == csum_next);
            end else begin
                active_next = 1'b1;
                cnt_next    = idx + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        csum_reg   <= csum_next;
        fields_reg <= fields_next;
        addr_reg   <= addr_next;
        tp_reg     <= tp_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> cnt_reg == '0)
        else $error("byte count not zero while idle");

    a_count_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < IDX_MAX)
        else $error("byte count beyond largest header");

    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept))
        else $error("result raised without an accepted request");

    a_last_byte_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (work && last) |-> idx[0] && idx >= 6'd19)
        else $error("header ended on a bad byte position");
`endif

endmodule

// File: tb/tb_ipv4_header_parse_check.sv
// testbench for the ipv4 header parse and checksum check block
`timescale 1ns / 1ps

module tb_ipv4_header_parse_check;
    import ihpc_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ihpc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ihpc_out_t m_data;

    ipv4_header_parse_check i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    ihpc_in_t  pending_req_q[$];
    ihpc_out_t expected_hdr_q[$];
    int        fail_cnt = 0;
    int        sent_cnt = 0;
    int        total_reqs = 0;
    int        hdr_bytes = 0;
    int        results_seen = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        long_hold_left = 0;
    bit        long_hold_done = 1'b0;
    bit        hdr_done;
    ihpc_out_t exp_hdr;

    // predictor state
    int          byte_idx = 0;
    logic [15:0] run_sum = '0;
    logic [7:0]  hi_byte = '0;
    logic [15:0] rx_csum = '0;
    logic [63:0] hdr_front = '0;
    logic [63:0] hdr_addr = '0;
    logic [15:0] ttl_proto = '0;
    bit          parsing = 1'b0;

    function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] s;
        s = 32'(a) + 32'(b);
        s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    function automatic bit hdr_parse_step(input ihpc_in_t req, output ihpc_out_t res);
        int idx;
        int hw;
        logic [7:0] b;
        b = req.header_byte;
        res = '0;
        if (req.start_of_header) begin
            byte_idx  = 0;
            run_sum   = '0;
            hi_byte   = '0;
            rx_csum   = '0;
            hdr_front = '0;
            hdr_addr  = '0;
            ttl_proto = '0;
            parsing   = 1'b1;
        end else if (!parsing) begin
            return 1'b0;
        end
        idx = byte_idx;
        if (idx < int'(IDX_TTL))
            hdr_front = {hdr_front[55:0], b};
        else if (idx < int'(IDX_CSUM))
            ttl_proto = {ttl_proto[7:0], b};
        else if (idx < int'(IDX_ADDR))
            rx_csum = {rx_csum[7:0], b};
        else if (idx < int'(IDX_ADDR_END))
            hdr_addr = {hdr_addr[55:0], b};
        // checksum word is summed as zero
        if (idx % 2 == 0)
            hi_byte = b;
        else if (idx != int'(IDX_CSUM_LO))
            run_sum = csum_add(run_sum, {hi_byte, b});
        // span follows the partially shifted length nibble, as the hardware does
        hw = int'(hdr_front[59:56]);
        if (hw < int'(MIN_HDR_WORDS))
            hw = int'(MIN_HDR_WORDS);
        if (idx + 1 < hw * 4) begin
            byte_idx = idx + 1;
            return 1'b0;
        end
        parsing  = 1'b0;
        byte_idx = 0;
        res.version        = hdr_front[63:60];
        res.header_words   = hdr_front[59:56];
        res.dscp           = hdr_front[55:50];
        res.ecn            = hdr_front[49:48];
        res.tot_len        = hdr_front[47:32];
        res.identification = hdr_front[31:16];
        res.flag_bits      = hdr_front[15:13];
        res.frag_off       = hdr_front[12:0];
        res.ttl            = ttl_proto[15:8];
        res.protocol       = ttl_proto[7:0];
        res.address_pair   = hdr_addr;
        res.checksum_ok    = (~run_sum == rx_csum);
        return 1'b1;
    endfunction

    // fill: 0 random bytes, 1 all zero, 2 all ones; keep < 0 sends the whole header
    task automatic queue_header(input logic [3:0] ver, input logic [3:0] hw, input int keep,
                                input bit good_csum, input int fill);
        logic [7:0]  hb [60];
        logic [15:0] sum;
        ihpc_in_t    req;
        int          span;
        int          n;
        span = (int'(hw) < int'(MIN_HDR_WORDS)) ? int'(MIN_HDR_WORDS) * 4 : int'(hw) * 4;
        for (int i = 0; i < 60; i++)
            hb[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
        hb[0] = {ver, hw};
        if (good_csum) begin
            hb[10] = 8'h00;
            hb[11] = 8'h00;
            sum = '0;
            for (int i = 0; i < span; i += 2)
                sum = csum_add(sum, {hb[i], hb[i+1]});
            {hb[10], hb[11]} = ~sum;
        end
        n = (keep < 0 || keep > span) ? span : keep;
        for (int i = 0; i < n; i++) begin
            req.header_byte     = hb[i];
            req.start_of_header = (i == 0);
            pending_req_q.push_back(req);
        end
        hdr_bytes += n;
    endtask

    task automatic queue_noise(input int n);
        ihpc_in_t req;
        for (int i = 0; i < n; i++) begin
            req.header_byte     = 8'($urandom_range(0, 255));
            req.start_of_header = 1'b0;
            pending_req_q.push_back(req);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // sender: new requests from the pending queue, idle bursts while the run is young
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent_cnt++;
                hdr_done = hdr_parse_step(s_data, exp_hdr);
                if (hdr_done)
                    expected_hdr_q.push_back(exp_hdr);
            end
            if (s_valid && !s_ready) begin
                // hold the request until it is taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_req_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_req_q.size() > 200 && (pending_req_q.size() / 150) % 3 != 0
                         && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(1, 14) - 1;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= pending_req_q.pop_front();
            end
        end
    end

    // receiver: checks each result, stalls in bursts and once for a long stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_hdr_q.size() == 0) begin
                    $error("result with no header pending: 0x%0h", m_data);
                    fail_cnt++;
                end else begin
                    exp_hdr = expected_hdr_q.pop_front();
                    check_field("version", 64'(exp_hdr.version), 64'(m_data.version));
                    check_field("header_words", 64'(exp_hdr.header_words),
                                64'(m_data.header_words));
                    check_field("dscp", 64'(exp_hdr.dscp), 64'(m_data.dscp));
                    check_field("ecn", 64'(exp_hdr.ecn), 64'(m_data.ecn));
                    check_field("tot_len", 64'(exp_hdr.tot_len),
                                64'(m_data.tot_len));
                    check_field("identification", 64'(exp_hdr.identification),
                                64'(m_data.identification));
                    check_field("flag_bits", 64'(exp_hdr.flag_bits), 64'(m_data.flag_bits));
                    check_field("frag_off", 64'(exp_hdr.frag_off),
                                64'(m_data.frag_off));
                    check_field("ttl", 64'(exp_hdr.ttl),
                                64'(m_data.ttl));
                    check_field("protocol", 64'(exp_hdr.protocol), 64'(m_data.protocol));
                    check_field("address_pair", exp_hdr.address_pair, m_data.address_pair);
                    check_field("checksum_ok", 64'(exp_hdr.checksum_ok),
                                64'(m_data.checksum_ok));
                end
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_seen == 15) begin
                // long back-pressure so the input side stalls
                long_hold_done = 1'b1;
                long_hold_left = 399;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (pending_req_q.size() > 200 && (pending_req_q.size() / 110) % 3 != 1
                         && $urandom_range(0, 11) == 0) begin
                rx_gap = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int          sel;
        logic [3:0]  hw;
        logic [3:0]  ver;
        int          span;
        int          fill;

        // directed: idle bytes, extremes, restart, short length, odd versions, options
        queue_noise(1);
        begin
            ihpc_in_t req;
            req.header_byte     = 8'hFF;
            req.start_of_header = 1'b0;
            pending_req_q.push_back(req);
        end
        queue_header(4'd4, 4'd5, -1, 1'b1, 1);
        queue_header(4'd15, 4'd15, -1, 1'b1, 2);
        queue_header(4'd4, 4'd5, 7, 1'b1, 0);
        queue_header(4'd0, 4'd0, -1, 1'b1, 0);
        queue_header(4'd6, 4'd4, -1, 1'b0, 0);
        queue_header(4'd4, 4'd6, -1, 1'b1, 0);
        queue_header(4'd4, 4'd5, -1, 1'b0, 2);

        while (hdr_bytes < 1450) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                hw = 4'd5;
            else if (sel < 16)
                hw = 4'($urandom_range(6, 8));
            else if (sel < 18)
                hw = 4'($urandom_range(0, 4));
            else
                hw = 4'($urandom_range(9, 15));
            ver  = ($urandom_range(0, 4) != 0) ? 4'd4 : 4'($urandom_range(0, 15));
            fill = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 2) : 0;
            span = (hw < 4'd5) ? 20 : int'(hw) * 4;
            sel  = $urandom_range(0, 99);
            if (sel < 80)
                queue_header(ver, hw, -1, $urandom_range(0, 9) < 7, fill);
            else if (sel < 90)
                queue_header(ver, hw, $urandom_range(1, span - 1), 1'b1, fill);
            else
                queue_noise($urandom_range(1, 4));
        end
        total_reqs = pending_req_q.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_cnt != total_reqs)
            @(posedge aclk);
        while (expected_hdr_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
